// ===== src/tfe_pkg.sv =====
// Shared constants, types and frame tables for the telemetry frame encoder.
package tfe_pkg;

  localparam int NUM_VALUES = 10;
  localparam int VALUE_W    = 32;
  localparam int FIELD_IDX_W = 4;

  localparam logic [7:0] SYNC_HEAD  = 8'hAA;
  localparam logic [7:0] SYNC_PLAIN = 8'hFF;
  localparam logic [7:0] SYNC_PARAM = 8'hAF;
  localparam logic [7:0] ID_USER    = 8'hF0;
  localparam logic [7:0] ID_PARAM   = 8'hE2;
  localparam logic [7:0] ID_CHECK   = 8'h00;
  localparam logic [7:0] ID_QUAT    = 8'h04;
  localparam logic [7:0] ID_MAG     = 8'h02;
  localparam logic [7:0] ID_ACCEL   = 8'h01;

  typedef enum logic [2:0] {
    KIND_USER  = 3'd0,
    KIND_PARAM = 3'd1,
    KIND_CHECK = 3'd2,
    KIND_QUAT  = 3'd3,
    KIND_MAG   = 3'd4,
    KIND_ACCEL = 3'd5
  } tfe_kind_t;

  typedef logic [NUM_VALUES-1:0][VALUE_W-1:0] tfe_values_t;

  typedef struct packed {
    logic load;
    logic byte_step;
    logic field_step;
  } tfe_shift_ctl_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic [7:0] data;
  } tfe_chk_ctl_t;

  function automatic logic kind_valid(input logic [2:0] kind);
    return kind <= KIND_ACCEL;
  endfunction

  function automatic logic [7:0] kind_sync(input logic [2:0] kind);
    case (kind)
      KIND_PARAM, KIND_CHECK: kind_sync = SYNC_PARAM;
      default:                kind_sync = SYNC_PLAIN;
    endcase
  endfunction

  function automatic logic [7:0] kind_len(input logic [2:0] kind);
    case (kind)
      KIND_USER:  kind_len = 8'd40;
      KIND_PARAM: kind_len = 8'd6;
      KIND_CHECK: kind_len = 8'd3;
      KIND_QUAT:  kind_len = 8'd9;
      KIND_MAG:   kind_len = 8'd14;
      KIND_ACCEL: kind_len = 8'd13;
      default:    kind_len = 8'd0;
    endcase
  endfunction

  function automatic logic [FIELD_IDX_W-1:0] kind_fields(input logic [2:0] kind);
    case (kind)
      KIND_USER:  kind_fields = 4'd10;
      KIND_PARAM: kind_fields = 4'd2;
      KIND_CHECK: kind_fields = 4'd3;
      KIND_QUAT:  kind_fields = 4'd5;
      KIND_MAG:   kind_fields = 4'd7;
      KIND_ACCEL: kind_fields = 4'd7;
      default:    kind_fields = 4'd1;
    endcase
  endfunction

  // Width in bytes of one payload field.
  function automatic logic [2:0] field_bytes(input logic [2:0] kind,
                                             input logic [FIELD_IDX_W-1:0] idx);
    case (kind)
      KIND_USER:  field_bytes = 3'd4;
      KIND_PARAM: field_bytes = (idx == 4'd0) ? 3'd2 : 3'd4;
      KIND_CHECK: field_bytes = 3'd1;
      KIND_QUAT:  field_bytes = (idx == 4'd4) ? 3'd1 : 3'd2;
      KIND_MAG: begin
        if (idx == 4'd3)      field_bytes = 3'd4;
        else if (idx >= 4'd5) field_bytes = 3'd1;
        else                  field_bytes = 3'd2;
      end
      KIND_ACCEL: field_bytes = (idx == 4'd6) ? 3'd1 : 3'd2;
      default:    field_bytes = 3'd1;
    endcase
  endfunction

endpackage

// ===== src/tfe_req_if.sv =====
// Request channel: frame kind, channel and payload values.
interface tfe_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [3:0]         channel;
  logic signed [31:0] value_0;
  logic signed [31:0] value_1;
  logic signed [31:0] value_2;
  logic signed [31:0] value_3;
  logic signed [31:0] value_4;
  logic signed [31:0] value_5;
  logic signed [31:0] value_6;
  logic signed [31:0] value_7;
  logic signed [31:0] value_8;
  logic signed [31:0] value_9;

  modport source (output valid, op, channel, value_0, value_1, value_2, value_3,
                  value_4, value_5, value_6, value_7, value_8, value_9,
                  input ready);
  modport sink (input valid, op, channel, value_0, value_1, value_2, value_3,
                value_4, value_5, value_6, value_7, value_8, value_9,
                output ready);
endinterface

// ===== src/tfe_byte_if.sv =====
// Byte channel: one frame byte and its end-of-frame mark.
interface tfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ===== src/tfe_shift.sv =====
// Payload shift line: words move down one field at a time, bytes one per step.
module tfe_shift (
  input  logic                   clk,
  input  tfe_pkg::tfe_shift_ctl_t ctl,
  input  tfe_pkg::tfe_values_t    values,
  output logic [7:0]             head_byte
);
  import tfe_pkg::*;

  logic [VALUE_W-1:0] words [NUM_VALUES];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < NUM_VALUES; i++) begin
        words[i] <= values[i];
      end
    end else if (ctl.field_step) begin
      // advance to the next field
      for (int i = 0; i < NUM_VALUES - 1; i++) begin
        words[i] <= words[i+1];
      end
      words[NUM_VALUES-1] <= '0;
    end else if (ctl.byte_step) begin
      words[0] <= {8'h00, words[0][VALUE_W-1:8]};
    end
  end

  assign head_byte = words[0][7:0];
endmodule

// ===== src/tfe_check.sv =====
// Running sum check and add check over the checked bytes of a frame.
module tfe_check (
  input  logic                  clk,
  input  logic                  rst,
  input  tfe_pkg::tfe_chk_ctl_t ctl,
  output logic [7:0]            sum_check,
  output logic [7:0]            add_check
);
  import tfe_pkg::*;

  logic [7:0] sum_next;

  assign sum_next = sum_check + ctl.data;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      sum_check <= '0;
      add_check <= '0;
    end else if (ctl.en) begin
      sum_check <= sum_next;
      add_check <= add_check + sum_next;
    end
  end
endmodule

// ===== src/tfe_seq.sv =====
// Frame sequencer: walks header, payload and checks, holds the output byte.
module tfe_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [2:0]              req_op,
  input  logic [3:0]              req_channel,
  input  logic [7:0]              head_byte,
  input  logic [7:0]              sum_check,
  input  logic [7:0]              add_check,
  output tfe_pkg::tfe_shift_ctl_t shift_ctl,
  output tfe_pkg::tfe_chk_ctl_t   chk_ctl,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    last_byte
);
  import tfe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAY,
    ST_SUM,
    ST_ADD
  } state_t;

  state_t                 state;
  logic [2:0]             kind;
  logic [3:0]             channel;
  logic [1:0]             hdr_pos;
  logic [FIELD_IDX_W-1:0] field_idx;
  logic [1:0]             byte_idx;

  logic       accept;
  logic       adv;
  logic       load_out;
  logic [7:0] frame_id;
  logic [7:0] hdr_byte;
  logic [2:0] fbytes;
  logic       field_end;
  logic       frame_end;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign adv       = !out_valid || out_ready;
  // a frame byte enters the output register this cycle
  assign load_out  = adv && (state inside {ST_HDR, ST_PAY, ST_SUM, ST_ADD});

  always_comb begin
    if (kind == KIND_USER) begin
      frame_id = ID_USER + {4'h0, (channel == 4'd0) ? 4'd1 : channel};
    end else begin
      case (kind)
        KIND_PARAM: frame_id = ID_PARAM;
        KIND_CHECK: frame_id = ID_CHECK;
        KIND_QUAT:  frame_id = ID_QUAT;
        KIND_MAG:   frame_id = ID_MAG;
        default:    frame_id = ID_ACCEL;
      endcase
    end
    case (hdr_pos)
      2'd0:    hdr_byte = SYNC_HEAD;
      2'd1:    hdr_byte = kind_sync(kind);
      2'd2:    hdr_byte = frame_id;
      default: hdr_byte = kind_len(kind);
    endcase
  end

  assign fbytes    = field_bytes(kind, field_idx);
  assign field_end = ({1'b0, byte_idx} + 3'd1) == fbytes;
  assign frame_end = (field_idx + 4'd1) == kind_fields(kind);

  always_comb begin
    shift_ctl.load       = accept && kind_valid(req_op);
    shift_ctl.byte_step  = (state == ST_PAY) && adv;
    shift_ctl.field_step = (state == ST_PAY) && adv && field_end;
    chk_ctl.clr          = accept;
    chk_ctl.en           = adv && ((state == ST_HDR) || (state == ST_PAY));
    chk_ctl.data         = (state == ST_HDR) ? hdr_byte : head_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      hdr_pos   <= '0;
      field_idx <= '0;
      byte_idx  <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          // drop unused kinds without a frame
          if (accept && kind_valid(req_op)) begin
            kind      <= req_op;
            channel   <= req_channel;
            hdr_pos   <= '0;
            field_idx <= '0;
            byte_idx  <= '0;
            state     <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (adv) begin
            out_byte  <= hdr_byte;
            last_byte <= 1'b0;
            hdr_pos   <= hdr_pos + 2'd1;
            if (hdr_pos == 2'd3) begin
              state <= ST_PAY;
            end
          end
        end
        ST_PAY: begin
          if (adv) begin
            out_byte  <= head_byte;
            last_byte <= 1'b0;
            if (field_end) begin
              byte_idx  <= '0;
              field_idx <= field_idx + 4'd1;
              if (frame_end) begin
                state <= ST_SUM;
              end
            end else begin
              byte_idx <= byte_idx + 2'd1;
            end
          end
        end
        ST_SUM: begin
          if (adv) begin
            out_byte  <= sum_check;
            last_byte <= 1'b0;
            state     <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (adv) begin
            out_byte  <= add_check;
            last_byte <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== src/telemetry_frame_encoder.sv =====
// Top level of the telemetry frame encoder.
// Usage:
//   req (sink) takes one frame request: kind in op, user channel, and ten
//   32-bit values. rsp (source) gives the frame one byte per item, with
//   last_byte high on the closing add check byte.
//   Frame: 0xAA, sync byte, frame id, length, little-endian payload fields,
//   sum check, add check. Frames run from 9 bytes (check reply) to 46 bytes
//   (user data).
// Start: an accepted request moves the sequencer to its header state, from
//   which the first byte is loaded into the output register once it is free.
// Throughput: one byte per cycle within a frame while rsp.ready is high;
//   the sequencer takes the next request only when idle, once the add
//   check byte is loaded. The payload shift line moves one byte per step.
// Stall: while a byte waits on rsp.ready the output register holds it and the
//   sequencer, shift line and checks all hold. A new request is taken once
//   the add check byte sits in the output register, even if not yet taken.
// Requests with op 6 or 7 are accepted and dropped; no bytes follow.
// Reset (rst, synchronous): sequencer idles, output empty, checks cleared.
module telemetry_frame_encoder (
  input  logic       clk,
  input  logic       rst,
  tfe_req_if.sink    req,
  tfe_byte_if.source rsp
);
  import tfe_pkg::*;

  tfe_shift_ctl_t shift_ctl;
  tfe_chk_ctl_t   chk_ctl;
  tfe_values_t    values;
  logic [7:0]     head_byte;
  logic [7:0]     sum_check;
  logic [7:0]     add_check;

  // Gather the payload words into one vector for the shift line.
  assign values = {req.value_9, req.value_8, req.value_7, req.value_6, req.value_5,
                   req.value_4, req.value_3, req.value_2, req.value_1, req.value_0};

  tfe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_op      (req.op),
    .req_channel (req.channel),
    .head_byte   (head_byte),
    .sum_check   (sum_check),
    .add_check   (add_check),
    .shift_ctl   (shift_ctl),
    .chk_ctl     (chk_ctl),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_byte    (rsp.out_byte),
    .last_byte   (rsp.last_byte)
  );

  // Payload bytes leave the shift line lowest byte first.
  tfe_shift u_shift (
    .clk       (clk),
    .ctl       (shift_ctl),
    .values    (values),
    .head_byte (head_byte)
  );

  // Checks accumulate over header and payload bytes only.
  tfe_check u_check (
    .clk       (clk),
    .rst       (rst),
    .ctl       (chk_ctl),
    .sum_check (sum_check),
    .add_check (add_check)
  );
endmodule

// ===== src/tfe_checker.sv =====
// Port-level checks for the telemetry frame encoder, bound to the top level.
module tfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [2:0] req_op,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_byte,
  input logic       rsp_last
);
  import tfe_pkg::*;

  // A stalled byte holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
    else $error("stalled output byte changed");

  // No request is taken in the middle of a frame.
  a_no_req_mid_frame: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request ready while frame in progress");

  // A valid kind starts a frame and blocks further requests.
  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_op <= KIND_ACCEL) |=> !req_ready)
    else $error("frame request did not start a frame");

  // An unused kind is dropped at once.
  a_unused_dropped: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_op > KIND_ACCEL) |=> req_ready && !(rsp_valid && !rsp_last))
    else $error("unused kind started a frame");

endmodule

bind telemetry_frame_encoder tfe_checker u_tfe_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_op    (req.op),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_byte  (rsp.out_byte),
  .rsp_last  (rsp.last_byte)
);
